@@ hw/rtl/sbf_pkg.sv @@
package sbf_pkg;

    localparam logic [7:0]  FIXED_HDR  = 8'h90;
    localparam logic [7:0]  NO_PROPS   = 8'h00;
    localparam logic [27:0] MAX_TOPICS = 28'd268435452;
    localparam int          QDEPTH     = 4;
    localparam int          QPTR_W     = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0]  code;
        logic        first;
        logic [15:0] pid;
        logic [27:0] rem;
        logic [1:0]  len_last;
        logic        pkt_end;
    } t_entry;

    typedef enum logic [5:0] {
        ST_HDR  = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_PIDH = 6'b000100,
        ST_PIDL = 6'b001000,
        ST_PROP = 6'b010000,
        ST_CODE = 6'b100000
    } t_state;

endpackage

@@ hw/rtl/sbf_front.sv @@
module sbf_front
    import sbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_reason_code,
    input  logic [15:0] i_packet_id,
    input  logic [27:0] i_topic_count,
    output t_entry      o_entry
);

    logic        r_in_packet;
    logic [27:0] r_codes_left;
    logic        n_in_packet;
    logic [27:0] n_codes_left;
    logic [27:0] cnt;
    logic [27:0] rem;
    logic [1:0]  len_last;
    logic [27:0] left_now;

    always_comb begin
        cnt = i_topic_count;
        if (cnt == 28'd0) begin
            cnt = 28'd1;
        end
        if (cnt > MAX_TOPICS) begin
            cnt = MAX_TOPICS;
        end
        rem = cnt + 28'd3;
        if (rem[27:21] != 7'd0) begin
            len_last = 2'd3;
        end else if (rem[20:14] != 7'd0) begin
            len_last = 2'd2;
        end else if (rem[13:7] != 7'd0) begin
            len_last = 2'd1;
        end else begin
            len_last = 2'd0;
        end
        left_now     = r_in_packet ? r_codes_left : cnt;
        n_codes_left = left_now - 28'd1;
        n_in_packet  = (n_codes_left != 28'd0);

        o_entry.code     = i_reason_code;
        o_entry.first    = !r_in_packet;
        o_entry.pid      = i_packet_id;
        o_entry.rem      = rem;
        o_entry.len_last = len_last;
        o_entry.pkt_end  = (n_codes_left == 28'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet  <= 1'b0;
            r_codes_left <= 28'd0;
        end else if (i_push) begin
            r_in_packet  <= n_in_packet;
            r_codes_left <= n_codes_left;
        end
    end

endmodule

@@ hw/rtl/sbf_queue.sv @@
module sbf_queue
    import sbf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/sbf_back.sv @@
module sbf_back
    import sbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_packet_end
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_len_idx;
    logic [1:0] n_len_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_packet_end;
    logic [7:0] n_byte;
    logic       n_last;
    logic       advance;
    logic       emit;
    logic [6:0] group;

    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = advance && i_q_valid;

    always_comb begin
        case (r_len_idx)
            2'd0:    group = i_entry.rem[6:0];
            2'd1:    group = i_entry.rem[13:7];
            2'd2:    group = i_entry.rem[20:14];
            default: group = i_entry.rem[27:21];
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_len_idx = r_len_idx;
        n_byte    = i_entry.code;
        n_last    = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            ST_HDR: begin
                if (i_entry.first) begin
                    n_byte    = FIXED_HDR;
                    n_state   = ST_LEN;
                    n_len_idx = 2'd0;
                end else begin
                    n_last = 1'b1;
                    o_pop  = emit;
                end
            end
            ST_LEN: begin
                n_byte = {(r_len_idx != i_entry.len_last), group};
                if (r_len_idx == i_entry.len_last) begin
                    n_state = ST_PIDH;
                end else begin
                    n_len_idx = r_len_idx + 2'd1;
                end
            end
            ST_PIDH: begin
                n_byte  = i_entry.pid[15:8];
                n_state = ST_PIDL;
            end
            ST_PIDL: begin
                n_byte  = i_entry.pid[7:0];
                n_state = ST_PROP;
            end
            ST_PROP: begin
                n_byte  = NO_PROPS;
                n_state = ST_CODE;
            end
            ST_CODE: begin
                n_last  = 1'b1;
                o_pop   = emit;
                n_state = ST_HDR;
            end
            default: begin
                n_state = ST_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HDR;
            r_len_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_state   <= n_state;
                r_len_idx <= n_len_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= n_byte;
            r_run_last   <= n_last;
            r_packet_end <= n_last && i_entry.pkt_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_packet_end = r_packet_end;

endmodule

@@ hw/rtl/suback_packet_framer.sv @@
// suback framer: reason codes in, suback packet bytes out
// input channel: i_in_valid / o_in_stall carries a reason code; the first item
//   of a packet also carries packet id and topic count, ignored on later items
// output channel: o_out_valid / i_out_stall carries one packet byte per item,
//   with run_last on the last byte of an input item and packet_end on the
//   final byte of the packet
// a first item expands into 6 to 9 bytes (header, 1-4 length bytes, id,
//   properties length, code); a later item gives its code byte only
// an accepted item is written into the queue, then into the sequencer's output register
// throughput: one output byte per unstalled cycle, set by the byte sequencer;
//   later items go one per cycle, a first item holds it for all of its bytes
// a 4-entry queue between the classifier and the sequencer; o_in_stall is
//   high only while that queue is full
// a stalled output holds its byte; the sequencer and then the queue back up
// reset (synchronous, active low) empties the queue and the output register
//   and closes any open packet
module suback_packet_framer
    import sbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_reason_code,
    input  logic [15:0] i_packet_id,
    input  logic [27:0] i_topic_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_packet_end
);

    t_entry front_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    sbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_reason_code (i_reason_code),
        .i_packet_id   (i_packet_id),
        .i_topic_count (i_topic_count),
        .o_entry       (front_entry)
    );

    sbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    sbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_packet_end (o_packet_end)
    );

endmodule

@@ bench/tb_suback_packet_framer.sv @@
`timescale 1ns / 1ps

module tb_suback_packet_framer;
    import sbf_pkg::*;

    typedef struct {
        logic [7:0]  code;
        logic [15:0] pid;
        logic [27:0] count;
    } code_item_t;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       pkt_end;
    } suback_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_reason_code = 8'h00;
    logic [15:0] i_packet_id = 16'h0000;
    logic [27:0] i_topic_count = 28'h0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_packet_end;

    code_item_t   codes_to_send[$];
    suback_byte_t bytes_due[$];
    code_item_t   next_code;
    suback_byte_t want;

    logic        pkt_open = 1'b0;
    logic [27:0] codes_owed = 28'h0;
    int          items_taken = 0;
    int          items_total = 0;
    int          bytes_seen = 0;
    int          mismatches = 0;
    int          cyc = 0;

    suback_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_reason_code (i_reason_code),
        .i_packet_id   (i_packet_id),
        .i_topic_count (i_topic_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_packet_end  (o_packet_end)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 50) begin
            $display("mismatch at byte %0d: %s", bytes_seen, msg);
        end
        mismatches++;
    endtask

    // expected packet bytes for one accepted reason code
    task automatic frame_code(input logic [7:0] code, input logic [15:0] pid,
                              input logic [27:0] count);
        logic [27:0] cnt;
        logic [31:0] rem;
        logic [7:0]  b;
        if (!pkt_open) begin
            cnt = count;
            if (cnt == 28'd0) cnt = 28'd1;
            if (cnt > MAX_TOPICS) cnt = MAX_TOPICS;
            rem = 32'(cnt) + 32'd3;
            bytes_due.push_back('{FIXED_HDR, 1'b0, 1'b0});
            do begin
                b = {1'b0, rem[6:0]};
                rem = rem >> 7;
                if (rem != 32'd0) b[7] = 1'b1;
                bytes_due.push_back('{b, 1'b0, 1'b0});
            end while (rem != 32'd0);
            bytes_due.push_back('{pid[15:8], 1'b0, 1'b0});
            bytes_due.push_back('{pid[7:0], 1'b0, 1'b0});
            bytes_due.push_back('{NO_PROPS, 1'b0, 1'b0});
            codes_owed = cnt;
        end
        codes_owed = codes_owed - 28'd1;
        bytes_due.push_back('{code, 1'b1, codes_owed == 28'd0});
        pkt_open = (codes_owed != 28'd0);
    endtask

    task automatic add_packet(input logic [15:0] pid, input logic [27:0] count,
                              input int n, input logic [7:0] first_code);
        code_item_t it;
        it.code = first_code;
        it.pid = pid;
        it.count = count;
        codes_to_send.push_back(it);
        // id and count on later items are don't-care
        for (int k = 1; k < n; k++) begin
            it.code = 8'($urandom);
            it.pid = 16'($urandom);
            it.count = 28'($urandom);
            codes_to_send.push_back(it);
        end
    endtask

    function automatic bit take_break();
        if (cyc >= 150 && cyc < 450) return 1'b0;
        return $urandom_range(99) < 26;
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                frame_code(i_reason_code, i_packet_id, i_topic_count);
                items_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (codes_to_send.size() != 0 && !take_break()) begin
                    next_code = codes_to_send.pop_front();
                    i_reason_code <= next_code.code;
                    i_packet_id <= next_code.pid;
                    i_topic_count <= next_code.count;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", o_out_byte));
                end else begin
                    want = bytes_due.pop_front();
                    if (o_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  o_out_byte, want.data));
                    if (o_run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  o_run_last, want.run_last));
                    if (o_packet_end !== want.pkt_end)
                        report_mismatch($sformatf("packet_end %b, want %b",
                                                  o_packet_end, want.pkt_end));
                end
                bytes_seen++;
            end
            i_out_stall <= take_break();
        end
    end

    initial begin
        int roll;
        int cnt;
        // zero count, id and code extremes, ignored fields on later items
        add_packet(16'h0000, 28'd0, 1, 8'h00);
        add_packet(16'hFFFF, 28'd1, 1, 8'hFF);
        add_packet(16'h1234, 28'd2, 2, 8'h80);
        add_packet(16'h00FF, 28'd3, 3, 8'h7F);
        add_packet(16'hFF00, 28'd5, 5, 8'h01);
        // length byte boundaries: one byte max, two byte min
        add_packet(16'($urandom), 28'd124, 124, 8'($urandom));
        add_packet(16'($urandom), 28'd125, 125, 8'($urandom));
        while (codes_to_send.size() < 356) begin
            roll = $urandom_range(99);
            cnt = (roll < 10) ? 0 : $urandom_range(1, (roll < 85) ? 6 : 40);
            add_packet(16'($urandom), 28'(cnt), (cnt == 0) ? 1 : cnt, 8'($urandom));
        end
        // saturated count, four length bytes; left open at the end
        add_packet(16'($urandom), 28'hFFFFFFF, 4, 8'($urandom));
        items_total = codes_to_send.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < items_total) @(posedge i_clk);
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
